/* src/gsa_pkg.sv */
//------------------------------------------------------------------------------
// gsa_pkg
// shared types, constants and codes of the generational slot allocator
//------------------------------------------------------------------------------
package gsa_pkg;

    localparam int SLOTS_DEFAULT = 1024;
    localparam int CNT_W         = 11;
    localparam int HSLOT_W       = 10;
    localparam int GEN_W         = 32;
    localparam int ID_W          = 64;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SLOT_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_ID  = 1'b1;

    localparam logic [2:0] OP_SPAWN    = 3'd0;
    localparam logic [2:0] OP_KILL     = 3'd1;
    localparam logic [2:0] OP_RESOLVE  = 3'd2;
    localparam logic [2:0] OP_CLEAR    = 3'd3;
    localparam logic [2:0] OP_SHUTDOWN = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_HALTED  = 3'd1;
    localparam logic [2:0] ST_INVALID = 3'd2;
    localparam logic [2:0] ST_STALE   = 3'd3;
    localparam logic [2:0] ST_BAD_ID  = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;

    localparam logic [GEN_W-1:0] GEN_MAX = '1;
    localparam logic [31:0]      SAT32   = '1;
    localparam logic [CNT_W-1:0] RET_MAX = '1;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [ID_W-1:0]    particle_id;
        logic [31:0]        handle_buffer;
        logic [HSLOT_W-1:0] handle_slot;
        logic [GEN_W-1:0]   handle_generation;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [HSLOT_W-1:0] slot;
        logic [GEN_W-1:0]   generation;
        logic [HSLOT_W-1:0] dense_index;
        logic               move_valid;
        logic [HSLOT_W-1:0] move_source;
        logic [CNT_W-1:0]   active_count;
        logic [CNT_W-1:0]   free_count;
        logic [CNT_W-1:0]   retired_count;
        logic [CNT_W-1:0]   peak_active;
        logic [31:0]        failed_spawns;
        logic [31:0]        stale_accesses;
    } rsp_t;

endpackage

/* src/gsa_core.sv */
//------------------------------------------------------------------------------
// gsa_core
// sequencer with slot, dense and free memories, read-modify-write per request
//------------------------------------------------------------------------------
module gsa_core #(
    parameter int SLOTS = gsa_pkg::SLOTS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [gsa_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [gsa_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  gsa_pkg::req_t                  req,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output gsa_pkg::rsp_t                  rsp
);
    localparam int AW = $clog2(SLOTS);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] NO_DENSE = '1;

    typedef enum logic [9:0] {
        S_INIT  = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_READ  = 10'b0000000100,
        S_EXEC  = 10'b0000001000,
        S_KILL2 = 10'b0000010000,
        S_CLRD  = 10'b0000100000,
        S_CLRS  = 10'b0001000000,
        S_REBLD = 10'b0010000000,
        S_REBL2 = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    // slot memory: dense index, generation, owner id
    typedef struct packed {
        logic [CW-1:0]               dense;
        logic [gsa_pkg::GEN_W-1:0]   gen;
        logic [gsa_pkg::ID_W-1:0]    owner;
    } slot_ent_t;

    slot_ent_t      slot_mem [SLOTS];
    logic [AW-1:0]  dense_mem[SLOTS];
    logic [AW-1:0]  free_mem [SLOTS];

    state_t state_reg, state_next;
    logic [CW-1:0] limit_reg;
    logic [31:0]   bufid_reg;
    logic [CW-1:0] free_top_reg, live_reg, peak_reg;
    logic [gsa_pkg::CNT_W-1:0] ret_reg;
    logic [31:0]   refused_reg, stale_reg;
    logic [gsa_pkg::ID_W-1:0] newest_reg;
    logic          halted_reg;
    logic [CW-1:0] ptr_reg;
    logic          clr_halt_reg;
    gsa_pkg::req_t req_reg;
    gsa_pkg::rsp_t rsp_reg;

    slot_ent_t     slot_rd_reg;
    logic [AW-1:0] dense_rd_reg, free_rd_reg;
    logic [AW-1:0] hole_reg;

    // memory port controls
    logic          s_we, s_re, d_we, d_re, f_we, f_re;
    logic [AW-1:0] s_waddr, s_raddr, d_waddr, d_raddr, f_waddr, f_raddr;
    slot_ent_t     s_wdata;
    logic [AW-1:0] d_wdata, f_wdata;

    always_ff @(posedge aclk) begin
        if (s_we) slot_mem[s_waddr] <= s_wdata;
        if (s_re) slot_rd_reg <= slot_mem[s_raddr];
        if (d_we) dense_mem[d_waddr] <= d_wdata;
        if (d_re) dense_rd_reg <= dense_mem[d_raddr];
        if (f_we) free_mem[f_waddr] <= f_wdata;
        if (f_re) free_rd_reg <= free_mem[f_raddr];
    end

    logic [AW-1:0] hs;
    logic          h_bad, h_stale, spawn_bad, spawn_full;
    logic [CW-1:0] lim_clamp;
    logic [CW-1:0] last;
    assign hs = req_reg.handle_slot[AW-1:0];
    assign last = live_reg - CW'(1);

    always_comb begin
        h_bad = (req_reg.particle_id == '0) || (req_reg.handle_buffer == '0)
            || (req_reg.handle_generation == '0)
            || (req_reg.handle_buffer != bufid_reg)
            || ({1'b0, req_reg.handle_slot} >= gsa_pkg::CNT_W'(limit_reg));
        h_stale = (slot_rd_reg.dense == NO_DENSE) || (slot_rd_reg.dense >= live_reg)
            || (slot_rd_reg.gen != req_reg.handle_generation)
            || (slot_rd_reg.owner != req_reg.particle_id);
        spawn_bad = (req_reg.particle_id == '0) || (req_reg.particle_id <= newest_reg);
        spawn_full = (free_top_reg == '0) || (live_reg >= CW'(SLOTS));
    end

    always_comb begin
        logic [gsa_pkg::CNT_W-1:0] v;
        v = cfg_data[gsa_pkg::CNT_W-1:0];
        if (v < gsa_pkg::CNT_W'(1)) lim_clamp = CW'(1);
        else if (32'(v) > 32'(SLOTS)) lim_clamp = CW'(SLOTS);
        else lim_clamp = CW'(v);
    end

    always_comb begin
        state_next = state_reg;
        s_we = 1'b0; s_re = 1'b0; s_waddr = '0; s_raddr = '0; s_wdata = '0;
        d_we = 1'b0; d_re = 1'b0; d_waddr = '0; d_raddr = '0; d_wdata = '0;
        f_we = 1'b0; f_re = 1'b0; f_waddr = '0; f_raddr = '0; f_wdata = '0;
        case (state_reg)
            S_INIT: begin
                s_we = 1'b1; s_waddr = ptr_reg[AW-1:0];
                s_wdata = '{dense: NO_DENSE, gen: gsa_pkg::GEN_W'(1), owner: '0};
                f_we = ptr_reg < limit_reg; f_waddr = ptr_reg[AW-1:0];
                f_wdata = AW'(limit_reg - CW'(1) - ptr_reg);
            end
            S_READ: begin
                s_re = 1'b1; s_raddr = hs;
                f_re = 1'b1; f_raddr = AW'(free_top_reg - CW'(1));
                d_re = 1'b1; d_raddr = last[AW-1:0];
            end
            S_EXEC: begin
                if (req_reg.opcode == gsa_pkg::OP_SPAWN && !spawn_bad && !spawn_full) begin
                    s_raddr = free_rd_reg; s_re = 1'b1;
                    d_we = 1'b1; d_waddr = live_reg[AW-1:0]; d_wdata = free_rd_reg;
                end else if (req_reg.opcode == gsa_pkg::OP_KILL && !h_bad && !h_stale) begin
                    s_we = 1'b1; s_waddr = hs;
                    s_wdata = '{dense: NO_DENSE,
                        gen: (slot_rd_reg.gen == gsa_pkg::GEN_MAX) ? slot_rd_reg.gen
                                                                  : slot_rd_reg.gen + 1'b1,
                        owner: '0};
                    if (slot_rd_reg.gen != gsa_pkg::GEN_MAX && free_top_reg < CW'(SLOTS)) begin
                        f_we = 1'b1; f_waddr = free_top_reg[AW-1:0]; f_wdata = hs;
                    end
                    if (slot_rd_reg.dense != last) begin
                        d_we = 1'b1; d_waddr = slot_rd_reg.dense[AW-1:0];
                        d_wdata = dense_rd_reg;
                        s_re = 1'b1; s_raddr = dense_rd_reg;
                    end
                end
            end
            S_KILL2: begin
                s_we = 1'b1; s_waddr = dense_rd_reg;
                s_wdata = '{dense: {1'b0, hole_reg}, gen: slot_rd_reg.gen,
                            owner: slot_rd_reg.owner};
            end
            S_CLRD: begin
                d_re = 1'b1; d_raddr = ptr_reg[AW-1:0];
            end
            S_CLRS: begin
                s_re = 1'b1; s_raddr = dense_rd_reg;
            end
            S_REBLD: begin
                s_re = 1'b1; s_raddr = AW'(ptr_reg - CW'(1));
            end
            S_REBL2: begin
                f_we = slot_rd_reg.gen != gsa_pkg::GEN_MAX;
                f_waddr = free_top_reg[AW-1:0];
                f_wdata = AW'(ptr_reg - CW'(1));
            end
            default: ;
        endcase
        // spawn writes owner after reading slot generation
        if (state_reg == S_OUT && rsp_reg.status == gsa_pkg::ST_OK
            && req_reg.opcode == gsa_pkg::OP_SPAWN && !halted_reg && spawn_w_reg) begin
            s_we = 1'b1; s_waddr = rsp_reg.slot[AW-1:0];
            s_wdata = '{dense: CW'(rsp_reg.dense_index), gen: slot_rd_reg.gen,
                        owner: req_reg.particle_id};
        end
        // clear pass second half: update slot read in previous cycle
        if (state_reg == S_CLRD && clr_wr_reg) begin
            s_we = 1'b1; s_waddr = clr_slot_reg;
            s_wdata = '{dense: NO_DENSE,
                gen: (slot_rd_reg.gen == gsa_pkg::GEN_MAX) ? slot_rd_reg.gen
                                                          : slot_rd_reg.gen + 1'b1,
                owner: '0};
        end
    end

    logic          spawn_w_reg;
    logic          clr_wr_reg;
    logic [AW-1:0] clr_slot_reg;

    assign req_ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    logic rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == gsa_pkg::SAT32) ? v : v + 32'd1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            limit_reg <= CW'(SLOTS);
            bufid_reg <= 32'd1;
            ptr_reg <= '0;
            free_top_reg <= CW'(SLOTS);
            live_reg <= '0; peak_reg <= '0; ret_reg <= '0;
            refused_reg <= '0; stale_reg <= '0; newest_reg <= '0;
            halted_reg <= 1'b0; rsp_valid_reg <= 1'b0;
            spawn_w_reg <= 1'b0; clr_wr_reg <= 1'b0; clr_halt_reg <= 1'b0;
        end else begin
            if (rsp_valid_reg && rsp_ready) rsp_valid_reg <= 1'b0;
            spawn_w_reg <= 1'b0;
            clr_wr_reg <= 1'b0;
            if (cfg_we && cfg_idx == gsa_pkg::REG_BUFFER_ID) bufid_reg <= cfg_data;
            if (cfg_we && cfg_idx == gsa_pkg::REG_SLOT_LIMIT) begin
                limit_reg <= lim_clamp;
                free_top_reg <= lim_clamp;
                live_reg <= '0; peak_reg <= '0; ret_reg <= '0;
                refused_reg <= '0; stale_reg <= '0; newest_reg <= '0;
                halted_reg <= 1'b0; ptr_reg <= '0;
                state_reg <= S_INIT;
            end else begin
                case (state_reg)
                    S_INIT: begin
                        ptr_reg <= ptr_reg + CW'(1);
                        if (ptr_reg == CW'(SLOTS - 1)) state_reg <= S_IDLE;
                    end
                    S_IDLE: begin
                        if (req_valid && req_ready) begin
                            req_reg <= req;
                            state_reg <= S_READ;
                        end
                    end
                    S_READ: state_reg <= S_EXEC;
                    S_EXEC: begin
                        rsp_reg <= '0;
                        rsp_reg.status <= gsa_pkg::ST_OK;
                        state_reg <= S_OUT;
                        if (halted_reg && req_reg.opcode != gsa_pkg::OP_SHUTDOWN) begin
                            rsp_reg.status <= gsa_pkg::ST_HALTED;
                        end else begin
                            case (req_reg.opcode)
                                gsa_pkg::OP_SPAWN: begin
                                    if (spawn_bad || spawn_full) begin
                                        rsp_reg.status <= spawn_bad ? gsa_pkg::ST_BAD_ID
                                                                    : gsa_pkg::ST_FULL;
                                        refused_reg <= sat_inc(refused_reg);
                                    end else begin
                                        rsp_reg.slot <= gsa_pkg::HSLOT_W'(free_rd_reg);
                                        rsp_reg.dense_index <= gsa_pkg::HSLOT_W'(live_reg);
                                        free_top_reg <= free_top_reg - CW'(1);
                                        live_reg <= live_reg + CW'(1);
                                        if (live_reg + CW'(1) > peak_reg)
                                            peak_reg <= live_reg + CW'(1);
                                        newest_reg <= req_reg.particle_id;
                                        spawn_w_reg <= 1'b1;
                                    end
                                end
                                gsa_pkg::OP_KILL, gsa_pkg::OP_RESOLVE: begin
                                    if (h_bad) rsp_reg.status <= gsa_pkg::ST_INVALID;
                                    else if (h_stale) begin
                                        rsp_reg.status <= gsa_pkg::ST_STALE;
                                        stale_reg <= sat_inc(stale_reg);
                                    end else begin
                                        rsp_reg.dense_index <=
                                            gsa_pkg::HSLOT_W'(slot_rd_reg.dense);
                                        if (req_reg.opcode == gsa_pkg::OP_KILL) begin
                                            live_reg <= last;
                                            hole_reg <= slot_rd_reg.dense[AW-1:0];
                                            if (slot_rd_reg.gen == gsa_pkg::GEN_MAX) begin
                                                if (ret_reg != gsa_pkg::RET_MAX)
                                                    ret_reg <= ret_reg + 1'b1;
                                            end else if (free_top_reg < CW'(SLOTS))
                                                free_top_reg <= free_top_reg + CW'(1);
                                            if (slot_rd_reg.dense != last) begin
                                                rsp_reg.move_valid <= 1'b1;
                                                rsp_reg.move_source <=
                                                    gsa_pkg::HSLOT_W'(last);
                                                state_reg <= S_KILL2;
                                            end
                                        end
                                    end
                                end
                                gsa_pkg::OP_CLEAR, gsa_pkg::OP_SHUTDOWN: begin
                                    if (!halted_reg) begin
                                        clr_halt_reg <=
                                            req_reg.opcode == gsa_pkg::OP_SHUTDOWN;
                                        ptr_reg <= '0;
                                        state_reg <= S_CLRD;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                    S_KILL2: state_reg <= S_OUT;
                    S_CLRD: begin
                        if (ptr_reg < live_reg) state_reg <= S_CLRS;
                        else begin
                            state_reg <= S_REBLD;
                            ptr_reg <= limit_reg;
                            live_reg <= '0;
                            free_top_reg <= '0;
                        end
                    end
                    S_CLRS: begin
                        clr_wr_reg <= 1'b1;
                        clr_slot_reg <= dense_rd_reg;
                        ptr_reg <= ptr_reg + CW'(1);
                        state_reg <= S_CLRD;
                    end
                    S_REBLD: begin
                        if (ptr_reg == '0) begin
                            if (clr_halt_reg) halted_reg <= 1'b1;
                            state_reg <= S_OUT;
                        end else state_reg <= S_REBL2;
                    end
                    S_REBL2: begin
                        if (slot_rd_reg.gen != gsa_pkg::GEN_MAX)
                            free_top_reg <= free_top_reg + CW'(1);
                        ptr_reg <= ptr_reg - CW'(1);
                        state_reg <= S_REBLD;
                    end
                    S_OUT: begin
                        rsp_valid_reg <= 1'b1;
                        rsp_reg.generation <= spawn_w_reg ? slot_rd_reg.gen
                                                          : rsp_reg.generation;
                        rsp_reg.active_count <= gsa_pkg::CNT_W'(live_reg);
                        rsp_reg.free_count <= gsa_pkg::CNT_W'(free_top_reg);
                        rsp_reg.retired_count <= ret_reg;
                        rsp_reg.peak_active <= gsa_pkg::CNT_W'(peak_reg);
                        rsp_reg.failed_spawns <= refused_reg;
                        rsp_reg.stale_accesses <= stale_reg;
                        state_reg <= S_IDLE;
                    end
                    default: state_reg <= S_INIT;
                endcase
                if (clr_wr_reg && slot_rd_reg.gen == gsa_pkg::GEN_MAX
                    && ret_reg != gsa_pkg::RET_MAX)
                    ret_reg <= ret_reg + 1'b1;
            end
        end
    end

endmodule

/* src/generational_slot_allocator.sv */
//------------------------------------------------------------------------------
// generational_slot_allocator
// generational slot map over a packed dense array
//------------------------------------------------------------------------------
// channel | direction | handshake          | payload
// s_      | in        | s_valid / s_ready  | s_req   (gsa_pkg::req_t)
// m_      | out       | m_valid / m_ready  | m_rsp   (gsa_pkg::rsp_t)
// cfg_    | in        | cfg_we             | cfg_index, cfg_data
// spawn, resolve and kill without a move pass read, execute and output states;
// kill with a move adds a state, needed by the single slot memory write port
// clear and shutdown walk live dense entries, then all slots below slot_limit
// after reset or a slot_limit write a pass over all SLOTS refills the memories
// a waiting result blocks the next request until taken
//------------------------------------------------------------------------------
module generational_slot_allocator #(
    parameter int SLOTS = gsa_pkg::SLOTS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [gsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gsa_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  gsa_pkg::req_t                  s_req,
    output logic                           m_valid,
    input  logic                           m_ready,
    output gsa_pkg::rsp_t                  m_rsp
);
    gsa_core #(.SLOTS(SLOTS)) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req       (s_req),
        .rsp_valid (m_valid),
        .rsp_ready (m_ready),
        .rsp       (m_rsp)
    );
endmodule

/* src/gsa_checker.sv */
//------------------------------------------------------------------------------
// gsa_checker
// port level checks of the generational slot allocator
//------------------------------------------------------------------------------
module gsa_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input gsa_pkg::rsp_t m_rsp
);
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rsp)) else $error("result changed");
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("request taken while result waits");
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_rsp.status <= gsa_pkg::ST_FULL) else $error("bad status");
    a_move: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rsp.move_valid |-> m_rsp.status == gsa_pkg::ST_OK)
        else $error("move without ok");
endmodule

bind generational_slot_allocator gsa_checker u_gsa_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_rsp(m_rsp)
);

/* test/testbench.sv */
//------------------------------------------------------------------------------
// testbench
// self-checking bench for the generational slot allocator: a scoreboard keeps
// its own slot map, free stack and counters, predicts one response per request
// and compares every field; directed handle and spawn corner cases come first,
// then random phases under changing slot limits and buffer ids
//------------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gsa_pkg::*;

    localparam int NSLOT = SLOTS_DEFAULT;
    localparam logic [CNT_W-1:0] NO_DENSE = '1;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_SLOT_LIMIT;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    req_t                  s_req     = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    rsp_t                  m_rsp;

    int  mismatches = 0;
    int  results_seen = 0;
    bit  long_hold = 1'b0;

    generational_slot_allocator dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_valid(s_valid), .s_ready(s_ready), .s_req(s_req),
        .m_valid(m_valid), .m_ready(m_ready), .m_rsp(m_rsp)
    );

    task automatic report(input string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    class slot_map_scoreboard;
        logic [CNT_W-1:0]   slot_to_dense [NSLOT];
        logic [HSLOT_W-1:0] dense_to_slot [NSLOT];
        logic [GEN_W-1:0]   gens [NSLOT];
        logic [ID_W-1:0]    owners [NSLOT];
        logic [HSLOT_W-1:0] free_list [NSLOT];
        int                 free_top, live, retired, peak, limit;
        logic [ID_W-1:0]    newest;
        logic [31:0]        refused, stale, buf_id;
        bit                 halted;
        rsp_t               pending_rsp [$];
        int                 requests;

        function void rebuild();
            for (int i = 0; i < NSLOT; i++) begin
                slot_to_dense[i] = NO_DENSE;
                dense_to_slot[i] = '0;
                gens[i] = 1;
                owners[i] = '0;
                free_list[i] = '0;
            end
            for (int i = 0; i < limit; i++) free_list[i] = limit - 1 - i;
            free_top = limit;
            live = 0; newest = '0; retired = 0; peak = 0;
            refused = '0; stale = '0; halted = 1'b0;
        endfunction

        function void reset();
            limit = NSLOT;
            buf_id = 32'd1;
            rebuild();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            int v;
            if (idx == REG_SLOT_LIMIT) begin
                v = val[CNT_W-1:0];
                if (v < 1) v = 1;
                if (v > NSLOT) v = NSLOT;
                limit = v;
                rebuild();
            end else begin
                buf_id = val;
            end
        endfunction

        function void retire_one();
            if (retired < 2047) retired++;
        endfunction

        function void clear_live();
            int s;
            for (int d = 0; d < live; d++) begin
                s = dense_to_slot[d];
                slot_to_dense[s] = NO_DENSE;
                owners[s] = '0;
                if (gens[s] == GEN_MAX) retire_one();
                else gens[s]++;
            end
            live = 0;
            free_top = 0;
            for (int i = limit; i > 0; i--)
                if (gens[i-1] != GEN_MAX) free_list[free_top++] = i - 1;
        endfunction

        function logic [2:0] check_handle(req_t q, output int d);
            logic [CNT_W-1:0] m;
            d = 0;
            if (q.particle_id == 0 || q.handle_buffer == 0 || q.handle_generation == 0 ||
                q.handle_buffer != buf_id || q.handle_slot >= limit)
                return ST_INVALID;
            m = slot_to_dense[q.handle_slot];
            if (m == NO_DENSE || m >= live || gens[q.handle_slot] != q.handle_generation ||
                owners[q.handle_slot] != q.particle_id) begin
                if (stale != SAT32) stale++;
                return ST_STALE;
            end
            d = m;
            return ST_OK;
        endfunction

        function rsp_t predict(req_t q);
            rsp_t r;
            int d, s, last, moved;
            r = '0;
            if (halted && q.opcode != OP_SHUTDOWN) begin
                r.status = ST_HALTED;
            end else begin
                case (q.opcode)
                    OP_SPAWN: begin
                        if (q.particle_id == 0 || q.particle_id <= newest) begin
                            r.status = ST_BAD_ID;
                            if (refused != SAT32) refused++;
                        end else if (free_top == 0 || live >= NSLOT) begin
                            r.status = ST_FULL;
                            if (refused != SAT32) refused++;
                        end else begin
                            s = free_list[--free_top];
                            d = live++;
                            dense_to_slot[d] = s;
                            slot_to_dense[s] = d;
                            owners[s] = q.particle_id;
                            newest = q.particle_id;
                            if (live > peak) peak = live;
                            r.slot = s;
                            r.generation = gens[s];
                            r.dense_index = d;
                        end
                    end
                    OP_KILL: begin
                        r.status = check_handle(q, d);
                        if (r.status == ST_OK) begin
                            s = q.handle_slot;
                            last = live - 1;
                            if (d != last) begin
                                moved = dense_to_slot[last];
                                dense_to_slot[d] = moved;
                                slot_to_dense[moved] = d;
                                r.move_valid = 1'b1;
                                r.move_source = last;
                            end
                            live--;
                            slot_to_dense[s] = NO_DENSE;
                            owners[s] = '0;
                            if (gens[s] == GEN_MAX) begin
                                retire_one();
                            end else begin
                                gens[s]++;
                                if (free_top < NSLOT) free_list[free_top++] = s;
                            end
                            r.dense_index = d;
                        end
                    end
                    OP_RESOLVE: begin
                        r.status = check_handle(q, d);
                        if (r.status == ST_OK) r.dense_index = d;
                    end
                    OP_CLEAR: clear_live();
                    OP_SHUTDOWN: begin
                        if (!halted) begin
                            clear_live();
                            halted = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            r.active_count = live;
            r.free_count = free_top;
            r.retired_count = retired;
            r.peak_active = peak;
            r.failed_spawns = refused;
            r.stale_accesses = stale;
            return r;
        endfunction

        function void note_request(req_t q);
            requests++;
            pending_rsp.push_back(predict(q));
        endfunction

        task automatic cmp(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
        endtask

        task automatic check_result(rsp_t g);
            rsp_t e;
            if (pending_rsp.size() == 0) begin
                report("response with no request outstanding");
                return;
            end
            e = pending_rsp.pop_front();
            cmp("status", g.status, e.status);
            cmp("slot", g.slot, e.slot);
            cmp("generation", g.generation, e.generation);
            cmp("dense_index", g.dense_index, e.dense_index);
            cmp("move_valid", g.move_valid, e.move_valid);
            cmp("move_source", g.move_source, e.move_source);
            cmp("active_count", g.active_count, e.active_count);
            cmp("free_count", g.free_count, e.free_count);
            cmp("retired_count", g.retired_count, e.retired_count);
            cmp("peak_active", g.peak_active, e.peak_active);
            cmp("failed_spawns", g.failed_spawns, e.failed_spawns);
            cmp("stale_accesses", g.stale_accesses, e.stale_accesses);
        endtask
    endclass

    slot_map_scoreboard sb = new();

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            sb.check_result(m_rsp);
        end
    end

    // response side back-pressure
    initial begin
        int n;
        @(posedge aresetn);
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                long_hold = 1'b0;
            end else begin
                n = $urandom_range(0, 9);
                if (n < 6) begin
                    m_ready <= 1'b1;
                    repeat ($urandom_range(1, 20)) @(posedge aclk);
                end else begin
                    m_ready <= 1'b0;
                    repeat (n < 9 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge aclk);
                end
            end
        end
    end

    task automatic send(req_t q);
        int p, gap;
        p = $urandom_range(0, 99);
        gap = p < 50 ? 0 : (p < 92 ? $urandom_range(1, 3) : $urandom_range(10, 40));
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req <= q;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(q);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_rsp.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    function automatic req_t mk(logic [2:0] op, logic [63:0] pid, logic [31:0] hb,
                                logic [9:0] hs, logic [31:0] hg);
        req_t q;
        q.opcode = op;
        q.particle_id = pid;
        q.handle_buffer = hb;
        q.handle_slot = hs;
        q.handle_generation = hg;
        return q;
    endfunction

    function automatic req_t live_handle(logic [2:0] op);
        int d, s;
        d = $urandom_range(0, sb.live - 1);
        s = sb.dense_to_slot[d];
        return mk(op, sb.owners[s], sb.buf_id, s, sb.gens[s]);
    endfunction

    req_t last_killed = '0;

    function automatic req_t random_request();
        req_t q;
        int p, k;
        p = $urandom_range(0, 99);
        if (p < 40) begin
            q = mk(OP_SPAWN, sb.newest + $urandom_range(1, 1000), $urandom, $urandom, $urandom);
        end else if (p < 45) begin
            q = mk(OP_SPAWN, $urandom_range(0, 1) ? 64'd0 : sb.newest, 0, 0, 0);
        end else if (p < 88) begin
            if (sb.live > 0 && $urandom_range(0, 9) < 8) q = live_handle(OP_KILL);
            else q = last_killed;
            q.opcode = p < 70 ? OP_KILL : OP_RESOLVE;
            if ($urandom_range(0, 4) == 0) begin
                k = $urandom_range(0, 6);
                case (k)
                    0: q.handle_buffer = '0;
                    1: q.handle_buffer ^= $urandom_range(1, 32'hFFFF_FFFF);
                    2: q.handle_slot = sb.limit < NSLOT ?
                                       $urandom_range(sb.limit, NSLOT - 1) : $urandom;
                    3: q.handle_generation = '0;
                    4: q.handle_generation += 1;
                    5: q.particle_id ^= 64'd1;
                    default: q.particle_id = '0;
                endcase
            end
        end else if (p < 91) begin
            q = mk(OP_CLEAR, 0, 0, 0, 0);
        end else if (p < 92) begin
            q = mk(OP_SHUTDOWN, 0, 0, 0, 0);
        end else begin
            q = mk($urandom_range(0, 7), {$urandom, $urandom}, $urandom, $urandom, $urandom);
        end
        return q;
    endfunction

    initial begin
        req_t q;
        int lim, choice;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        sb.reset();

        // directed corners at the default limit and buffer id, then at a clamped limit and buffer id zero
        send(mk(OP_SPAWN, 64'd5, 0, 0, 0));
        send(mk(OP_SPAWN, 64'd5, 0, 0, 0));
        send(mk(OP_SPAWN, 64'd0, 0, 0, 0));
        send(mk(OP_SPAWN, 64'd9, 0, 0, 0));
        send(mk(OP_SPAWN, 64'd12, 0, 0, 0));
        send(mk(OP_RESOLVE, 64'd5, 32'd1, 10'd0, 32'd1));
        send(mk(OP_KILL, 64'd5, 32'd1, 10'd0, 32'd1));
        send(mk(OP_KILL, 64'd5, 32'd1, 10'd0, 32'd1));
        send(mk(OP_RESOLVE, 64'd9, 32'd1, 10'd1, 32'd0));
        send(mk(OP_RESOLVE, 64'd9, 32'd0, 10'd1, 32'd1));
        send(mk(OP_RESOLVE, 64'd9, 32'd2, 10'd1, 32'd1));
        send(mk(OP_RESOLVE, 64'd9, 32'd1, 10'd1023, 32'd1));
        send(mk(3'd7, 64'd9, 32'd1, 10'd1, 32'd1));
        send(mk(OP_CLEAR, 0, 0, 0, 0));
        send(mk(OP_SPAWN, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0));
        send(mk(OP_SPAWN, 64'd20, 0, 0, 0));
        send(mk(OP_SHUTDOWN, 0, 0, 0, 0));
        send(mk(OP_SPAWN, 64'd30, 0, 0, 0));
        send(mk(OP_SHUTDOWN, 0, 0, 0, 0));
        send(mk(OP_RESOLVE, 64'd9, 32'd1, 10'd1, 32'd2));
        write_reg(REG_SLOT_LIMIT, 32'd0);
        write_reg(REG_BUFFER_ID, 32'd0);
        send(mk(OP_SPAWN, 64'd1, 0, 0, 0));
        send(mk(OP_SPAWN, 64'd2, 0, 0, 0));
        send(mk(OP_RESOLVE, 64'd1, 32'd0, 10'd0, 32'd1));

        for (int ph = 0; ph < 10; ph++) begin
            choice = $urandom_range(0, 9);
            case (choice)
                0: lim = 1;
                1: lim = 2;
                2: lim = 3;
                3: lim = 5;
                4: lim = 16;
                5: lim = 40;
                6: lim = 1024;
                7: lim = 2047;
                default: lim = $urandom_range(1, 1024);
            endcase
            if (ph == 1) lim = 8;
            if (ph == 5) lim = 1024;
            write_reg(REG_SLOT_LIMIT, lim);
            write_reg(REG_BUFFER_ID, ph == 3 ? 32'd0 :
                      (ph == 6 ? 32'hFFFF_FFFF : $urandom_range(1, 32'hFFFF_FFFF)));
            if (ph == 1) long_hold = 1'b1;
            for (int i = 0; i < 55; i++) begin
                if (i == 27) wait_drained();
                q = random_request();
                send(q);
                if (q.opcode == OP_KILL && sb.pending_rsp[$].status == ST_OK) last_killed = q;
            end
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        $display("ran %0d requests over 10 random phases plus directed handle and spawn cases",
                 sb.requests);
        $display("checked %0d responses, %0d field mismatches", results_seen, mismatches);
        if (mismatches == 0 && sb.pending_rsp.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

/* generational_slot_allocator.f */
src/gsa_pkg.sv
src/gsa_core.sv
src/generational_slot_allocator.sv
src/gsa_checker.sv
test/testbench.sv
